// ----- rtl/csb_pkg.sv -----
`default_nettype none

package csb_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int STORE_AW    = 14;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 16;
    localparam int DIM_W       = 11;
    localparam int FB_AW       = 20;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic advance;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic stall;
        logic fin_done;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/csb_ram.sv -----
`default_nettype none

module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/csb_ctrl.sv -----
`default_nettype none

module csb_ctrl
    import csb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_s_action,
    output logic         o_s_tready,
    input  wire t_status i_sts,
    output t_cmd         o_cmd,
    output t_state       o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_s_action == ACT_DRAW) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last && !i_sts.stall) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.fin_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.load  = i_s_tvalid && i_s_action == ACT_LOAD;
                o_cmd.start = i_s_tvalid && i_s_action == ACT_DRAW;
            end
            S_SCAN:   o_cmd.advance = 1'b1;
            S_FINISH: o_cmd.finish  = 1'b1;
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ----- rtl/csb_dp.sv -----
`default_nettype none

module csb_dp
    import csb_pkg::*;
#(
    parameter int CELL_WIDTH   = 8,
    parameter int CELL_HEIGHT  = 8,
    parameter int SPRITE_COUNT = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_sts,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [DIM_W-1:0]       i_cfg_data,
    input  wire logic                   i_m_tready,
    output logic                        o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int CELL_PIX = CELL_WIDTH * CELL_HEIGHT;
    localparam int RW       = (CELL_HEIGHT > 1) ? $clog2(CELL_HEIGHT) : 1;
    localparam int CW       = (CELL_WIDTH > 1) ? $clog2(CELL_WIDTH) : 1;
    localparam int PROD_W   = 2 * DIM_W;

    // input fields
    logic [STORE_AW-1:0] s_load_addr;
    logic [PIX_W-1:0]    s_load_pix;
    logic [POS_W-1:0]    s_pos_x;
    logic [POS_W-1:0]    s_pos_y;
    logic [7:0]          s_index;
    logic                s_mode;
    logic [PIX_W-1:0]    s_mcolor;

    assign s_load_addr = i_s_tdata[13:0];
    assign s_load_pix  = i_s_tdata[21:14];
    assign s_pos_x     = i_s_tdata[37:22];
    assign s_pos_y     = i_s_tdata[53:38];
    assign s_index     = i_s_tdata[61:54];
    assign s_mode      = i_s_tdata[62];
    assign s_mcolor    = i_s_tdata[70:63];

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [POS_W-1:0]    r_px;
    logic [POS_W-1:0]    r_py;
    logic                r_idx_ok;
    logic                r_mode;
    logic [PIX_W-1:0]    r_mcolor;
    logic [STORE_AW-1:0] r_src;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;

    logic                r_b_valid;
    logic [PROD_W-1:0]   r_b_prod;
    logic [DIM_W-1:0]    r_b_x;

    logic                r_pend_v;
    logic [FB_AW-1:0]    r_pend_addr;
    logic [PIX_W-1:0]    r_pend_color;

    logic                r_out_v;
    logic [FB_AW-1:0]    r_out_addr;
    logic [PIX_W-1:0]    r_out_color;
    logic                r_out_wv;
    logic                r_out_last;

    logic [POS_W:0]      sy;
    logic [POS_W:0]      sx;
    logic                vis_a;
    logic                adv;
    logic [PIX_W-1:0]    rdata;
    logic                hit;
    logic                stall;
    logic                out_free;
    logic                fin_do;
    logic [PROD_W-1:0]   b_sum;
    logic [FB_AW-1:0]    b_addr;
    logic [PIX_W-1:0]    b_color;
    logic                scan_last;

    assign sy = {r_py[POS_W-1], r_py} + (POS_W+1)'(r_row);
    assign sx = {r_px[POS_W-1], r_px} + (POS_W+1)'(r_col);

    assign vis_a = r_idx_ok
                && !sy[POS_W] && (sy[POS_W-1:0] < POS_W'(r_height))
                && !sx[POS_W] && (sx[POS_W-1:0] < POS_W'(r_width));

    assign out_free  = !r_out_v || i_m_tready;
    assign hit       = r_b_valid && (rdata != '0);
    assign stall     = hit && r_pend_v && !out_free;
    assign adv       = i_cmd.advance && !stall;
    assign fin_do    = i_cmd.finish && !r_b_valid && out_free;
    assign scan_last = (r_row == RW'(CELL_HEIGHT - 1)) && (r_col == CW'(CELL_WIDTH - 1));

    assign b_sum   = r_b_prod + PROD_W'(r_b_x);
    assign b_addr  = b_sum[FB_AW-1:0];
    assign b_color = r_mode ? r_mcolor : rdata;

    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (s_load_addr),
        .i_wdata (s_load_pix),
        .i_re    (adv),
        .i_raddr (r_src),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DIM_W'(128);
            r_height  <= DIM_W'(128);
            r_b_valid <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end

            if (adv) begin
                r_b_valid <= vis_a;
            end else if (!stall) begin
                r_b_valid <= 1'b0;
            end

            if (fin_do || (hit && !stall && r_pend_v)) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end

            if (hit && !stall) begin
                r_pend_v <= 1'b1;
            end else if (fin_do) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px     <= s_pos_x;
            r_py     <= s_pos_y;
            r_idx_ok <= {1'b0, s_index} < 9'(SPRITE_COUNT);
            r_mode   <= s_mode;
            r_mcolor <= s_mcolor;
            r_src    <= STORE_AW'(s_index * CELL_PIX);
            r_row    <= '0;
            r_col    <= '0;
        end else if (adv) begin
            r_src <= r_src + 1'b1;
            if (r_col == CW'(CELL_WIDTH - 1)) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end

        if (adv) begin
            r_b_prod <= PROD_W'(sy[DIM_W-1:0]) * PROD_W'(r_width);
            r_b_x    <= sx[DIM_W-1:0];
        end

        if (hit && !stall) begin
            r_pend_addr  <= b_addr;
            r_pend_color <= b_color;
            if (r_pend_v) begin
                r_out_addr  <= r_pend_addr;
                r_out_color <= r_pend_color;
                r_out_wv    <= 1'b1;
                r_out_last  <= 1'b0;
            end
        end

        if (fin_do) begin
            r_out_last <= 1'b1;
            r_out_wv   <= r_pend_v;
            if (r_pend_v) begin
                r_out_addr  <= r_pend_addr;
                r_out_color <= r_pend_color;
            end else begin
                r_out_addr  <= '0;
                r_out_color <= '0;
            end
        end
    end

    assign o_sts.scan_last = scan_last;
    assign o_sts.stall     = stall;
    assign o_sts.fin_done  = fin_do;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {(OUT_TDATA_W - FB_AW - PIX_W)'(0), r_out_color, r_out_addr};
    assign o_m_tuser  = r_out_wv;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/clipped_sprite_blitter.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: load, draw fields; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: address, color; tuser, tlast
// cfg       in   i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// Load transaction: writes the sprite store when accepted, no output.
// Draw transaction: scans CELL_WIDTH*CELL_HEIGHT cell pixels, one store read per cycle
// unless the scan is stalled, then drains the read and flushes the final write.
// Reset is synchronous, active low; the sprite store is not cleared.
// A drawn pixel freezes the scan while a write is pending and the output is full.
`default_nettype none

module clipped_sprite_blitter
    import csb_pkg::*;
#(
    parameter int CELL_WIDTH   = 8,
    parameter int CELL_HEIGHT  = 8,
    parameter int SPRITE_COUNT = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // load_address, load_pixel, pos_x, pos_y, sprite_index, mask_mode, mask_color
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // write_address, write_color
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // write_valid
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [DIM_W-1:0]       i_cfg_data
);

    t_cmd    cmd;
    t_status sts;
    t_state  state;

    csb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_action (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    csb_dp #(
        .CELL_WIDTH   (CELL_WIDTH),
        .CELL_HEIGHT  (CELL_HEIGHT),
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state != S_IDLE |-> !s_axis_tready)
        else $error("input accepted during draw");

    a_finish_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        state == S_FINISH && sts.fin_done |=> state == S_IDLE && m_axis_tvalid && m_axis_tlast)
        else $error("finish did not emit final write");

    a_null_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty result malformed");

    a_no_advance_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.advance && sts.stall |=> $stable(m_axis_tdata))
        else $error("output changed while scan stalled");

endmodule

`default_nettype wire
